@@ rtl/fmrm_pkg.sv @@
`default_nettype none

package fmrm_pkg;

   // table depth default and register reset
   localparam int unsigned MAX_REGIONS_DEF = 32;
   localparam logic [7:0]  USABLE_TYPE_RESET = 8'd7;

   // 4096-byte pages
   localparam int unsigned PAGE_SHIFT = 12;

   localparam int unsigned ADDR_W  = 64;
   localparam int unsigned PAGES_W = 52;
   localparam int unsigned TYPE_W  = 8;
   localparam int unsigned INDEX_W = 5;
   localparam int unsigned COUNT_W = 6;

   typedef enum logic [1:0] {
      ACT_IGNORED  = 2'd0,
      ACT_MERGED   = 2'd1,
      ACT_APPENDED = 2'd2,
      ACT_DROPPED  = 2'd3
   } action_type;

endpackage

`default_nettype wire

@@ rtl/fmrm_ifs.sv @@
`default_nettype none

interface fmrm_req_if;
   logic                            valid;
   logic                            ready;
   logic                            first_of_map;
   logic [fmrm_pkg::TYPE_W-1:0]     mem_type;
   logic [fmrm_pkg::ADDR_W-1:0]     phys_start;
   logic [fmrm_pkg::PAGES_W-1:0]    page_count;

   modport source (
      output valid, first_of_map, mem_type, phys_start, page_count,
      input  ready
   );
   modport sink (
      input  valid, first_of_map, mem_type, phys_start, page_count,
      output ready
   );
endinterface

interface fmrm_rsp_if;
   logic                            valid;
   logic                            ready;
   fmrm_pkg::action_type            action;
   logic [fmrm_pkg::INDEX_W-1:0]    entry_index;
   logic [fmrm_pkg::ADDR_W-1:0]     entry_base;
   logic [fmrm_pkg::ADDR_W-1:0]     entry_size;
   logic [fmrm_pkg::COUNT_W-1:0]    count_now;
   logic [fmrm_pkg::ADDR_W-1:0]     bytes_total;
   logic                            map_usable;

   modport source (
      output valid, action, entry_index, entry_base, entry_size,
             count_now, bytes_total, map_usable,
      input  ready
   );
   modport sink (
      input  valid, action, entry_index, entry_base, entry_size,
             count_now, bytes_total, map_usable,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/free_memory_region_merger.sv @@
`default_nettype none

// Channel   Dir   Handshake      Carries
// req_ch    in    valid/ready    first_of_map, mem_type, phys_start, page_count
// rsp_ch    out   valid/ready    action, entry_index, entry_base, entry_size,
//                                count_now, bytes_total, map_usable
// csr_*     in    write enable   usable_type (8 bits, no read-back)
//
// Steps: accept, one table read per cycle through the region memory read port
// with the compare on the registered read, merge or append, result load. A merge
// stops at the first entry hit, a miss reads every held entry; an ignored
// descriptor skips the scan.
// Reset: synchronous, active high; empties the table count, the byte total and
// the output register, and sets usable_type to 7. No clearing pass.
// Stalls: the result register holds a transaction until taken; the next
// request is accepted while it waits, and only the final load waits for it.

module free_memory_region_merger #(
   parameter int unsigned MAX_REGIONS = fmrm_pkg::MAX_REGIONS_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   fmrm_req_if.sink                      req_ch,
   fmrm_rsp_if.source                    rsp_ch,
   input  wire                           csr_we,
   input  wire [fmrm_pkg::TYPE_W-1:0]    csr_wdata
);

   localparam int unsigned IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);
   localparam int unsigned AW    = fmrm_pkg::ADDR_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REGIONS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MERGE,
      ST_APPEND,
      ST_EMIT
   } state_type;

   // region table, stored as base and wrapped end
   logic [AW-1:0] base_mem [MAX_REGIONS];
   logic [AW-1:0] end_mem  [MAX_REGIONS];

   state_type                     state_ff, state_in;
   logic [fmrm_pkg::TYPE_W-1:0]   usable_ff, usable_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [AW-1:0]                 total_ff, total_in;

   // descriptor under work
   logic [AW-1:0]                 start_ff, start_in;
   logic [AW-1:0]                 new_end_ff, new_end_in;

   // scan pipeline: issue pointer, then compare on the registered read
   logic [CNT_W-1:0]              iss_ff, iss_in;
   logic                          cmp_v_ff, cmp_v_in;
   logic [IDX_W-1:0]              cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]              hit_idx_ff, hit_idx_in;
   logic [AW-1:0]                 rd_base_ff, rd_end_ff;

   // pending result
   fmrm_pkg::action_type          res_act_ff, res_act_in;
   logic [IDX_W-1:0]              res_idx_ff, res_idx_in;
   logic [AW-1:0]                 res_base_ff, res_base_in;
   logic [AW-1:0]                 res_end_ff, res_end_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   fmrm_pkg::action_type          rsp_act_ff, rsp_act_in;
   logic [fmrm_pkg::INDEX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [AW-1:0]                 rsp_base_ff, rsp_base_in;
   logic [AW-1:0]                 rsp_size_ff, rsp_size_in;
   logic [fmrm_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [AW-1:0]                 rsp_total_ff, rsp_total_in;
   logic                          rsp_usable_ff, rsp_usable_in;

   // memory port controls
   logic                          mem_rd;
   logic [IDX_W-1:0]              rd_addr;
   logic                          mem_we;
   logic [IDX_W-1:0]              wr_addr;
   logic [AW-1:0]                 wr_base;
   logic [AW-1:0]                 wr_end;

   logic [AW-1:0]                 size;
   logic [AW-1:0]                 total_base;
   logic                          hit;
   logic                          out_free;
   logic [CNT_W+fmrm_pkg::COUNT_W-1:0] count_ext;
   logic [IDX_W+fmrm_pkg::INDEX_W-1:0] idx_ext;

   assign req_ch.ready = (state_ff == ST_IDLE);

   assign size       = {req_ch.page_count, {fmrm_pkg::PAGE_SHIFT{1'b0}}};
   assign total_base = req_ch.first_of_map ? '0 : total_ff;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;

   // touching counts as a match, so the test is on non-strict bounds
   assign hit = cmp_v_ff && !((new_end_ff < rd_base_ff) || (start_ff > rd_end_ff));

   // low bits of count and index as carried on the result
   assign count_ext = {{fmrm_pkg::COUNT_W{1'b0}}, count_ff};
   assign idx_ext   = {{fmrm_pkg::INDEX_W{1'b0}}, res_idx_ff};

   always_comb begin
      state_in      = state_ff;
      usable_in     = csr_we ? csr_wdata : usable_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      start_in      = start_ff;
      new_end_in    = new_end_ff;
      iss_in        = iss_ff;
      cmp_v_in      = cmp_v_ff;
      cmp_idx_in    = cmp_idx_ff;
      hit_idx_in    = hit_idx_ff;
      res_act_in    = res_act_ff;
      res_idx_in    = res_idx_ff;
      res_base_in   = res_base_ff;
      res_end_in    = res_end_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_act_in    = rsp_act_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_base_in   = rsp_base_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_usable_in = rsp_usable_ff;
      mem_rd        = 1'b0;
      rd_addr       = iss_ff[IDX_W-1:0];
      mem_we        = 1'b0;
      wr_addr       = hit_idx_ff;
      wr_base       = res_base_ff;
      wr_end        = res_end_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.first_of_map) begin
                  count_in = '0;
                  total_in = '0;
               end
               start_in   = req_ch.phys_start;
               new_end_in = req_ch.phys_start + size;
               if ((req_ch.mem_type == usable_ff) && (req_ch.page_count != '0)) begin
                  total_in = total_base + size;
                  iss_in   = '0;
                  cmp_v_in = 1'b0;
                  state_in = ST_SCAN;
               end else begin
                  res_act_in  = fmrm_pkg::ACT_IGNORED;
                  res_idx_in  = '0;
                  res_base_in = '0;
                  res_end_in  = '0;
                  state_in    = ST_EMIT;
               end
            end
         end
         ST_SCAN: begin
            if (hit) begin
               hit_idx_in = cmp_idx_ff;
               cmp_v_in   = 1'b0;
               state_in   = ST_MERGE;
            end else if (iss_ff < count_ff) begin
               mem_rd     = 1'b1;
               cmp_v_in   = 1'b1;
               cmp_idx_in = iss_ff[IDX_W-1:0];
               iss_in     = iss_ff + 1'b1;
            end else if (cmp_v_ff) begin
               // last entry missed, drain the pipe
               cmp_v_in = 1'b0;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_MERGE: begin
            res_act_in  = fmrm_pkg::ACT_MERGED;
            res_idx_in  = hit_idx_ff;
            res_base_in = (start_ff < rd_base_ff) ? start_ff : rd_base_ff;
            res_end_in  = (new_end_ff > rd_end_ff) ? new_end_ff : rd_end_ff;
            mem_we      = 1'b1;
            wr_addr     = hit_idx_ff;
            wr_base     = res_base_in;
            wr_end      = res_end_in;
            state_in    = ST_EMIT;
         end
         ST_APPEND: begin
            if (count_ff >= MAX_CNT) begin
               res_act_in  = fmrm_pkg::ACT_DROPPED;
               res_idx_in  = '0;
               res_base_in = '0;
               res_end_in  = '0;
            end else begin
               res_act_in  = fmrm_pkg::ACT_APPENDED;
               res_idx_in  = count_ff[IDX_W-1:0];
               res_base_in = start_ff;
               res_end_in  = new_end_ff;
               mem_we      = 1'b1;
               wr_addr     = count_ff[IDX_W-1:0];
               wr_base     = start_ff;
               wr_end      = new_end_ff;
               count_in    = count_ff + 1'b1;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_act_in    = res_act_ff;
               rsp_idx_in    = idx_ext[fmrm_pkg::INDEX_W-1:0];
               rsp_base_in   = res_base_ff;
               rsp_size_in   = res_end_ff - res_base_ff;
               rsp_count_in  = count_ext[fmrm_pkg::COUNT_W-1:0];
               rsp_total_in  = total_ff;
               rsp_usable_in = (count_ff != '0);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         usable_ff    <= fmrm_pkg::USABLE_TYPE_RESET;
         count_ff     <= '0;
         total_ff     <= '0;
         cmp_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         usable_ff    <= usable_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         cmp_v_ff     <= cmp_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_ff      <= start_in;
      new_end_ff    <= new_end_in;
      iss_ff        <= iss_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_idx_ff    <= hit_idx_in;
      res_act_ff    <= res_act_in;
      res_idx_ff    <= res_idx_in;
      res_base_ff   <= res_base_in;
      res_end_ff    <= res_end_in;
      rsp_act_ff    <= rsp_act_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_usable_ff <= rsp_usable_in;
   end

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         base_mem[wr_addr] <= wr_base;
         end_mem[wr_addr]  <= wr_end;
      end
      if (mem_rd) begin
         rd_base_ff <= base_mem[rd_addr];
         rd_end_ff  <= end_mem[rd_addr];
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.action      = rsp_act_ff;
   assign rsp_ch.entry_index = rsp_idx_ff;
   assign rsp_ch.entry_base  = rsp_base_ff;
   assign rsp_ch.entry_size  = rsp_size_ff;
   assign rsp_ch.count_now   = rsp_count_ff;
   assign rsp_ch.bytes_total = rsp_total_ff;
   assign rsp_ch.map_usable  = rsp_usable_ff;

   // table never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("region count above table depth");

   // an accepted transaction always leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff != ST_IDLE))
      else $error("request accepted but sequencer stayed idle");

   // compares only look at held entries
   a_cmp_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && cmp_v_ff) |-> ({1'b0, cmp_idx_ff} < {1'b0, count_ff}))
      else $error("compare on entry beyond region count");

   // a merge writes back an entry that was held
   a_merge_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> ({1'b0, hit_idx_ff} < {1'b0, count_ff}))
      else $error("merge into entry beyond region count");

   // the result register is only reloaded once it is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_ff && !rsp_ch.ready) |=> (state_ff == ST_EMIT))
      else $error("result loaded over a pending transaction");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TYPE_W     = fmrm_pkg::TYPE_W;
   localparam int unsigned ADDR_W     = fmrm_pkg::ADDR_W;
   localparam int unsigned PAGES_W    = fmrm_pkg::PAGES_W;
   localparam int unsigned INDEX_W    = fmrm_pkg::INDEX_W;
   localparam int unsigned COUNT_W    = fmrm_pkg::COUNT_W;
   localparam int unsigned PAGE_SHIFT = fmrm_pkg::PAGE_SHIFT;

   // Table depth matches the default build of the merger.
   localparam int unsigned TABLE_DEPTH = fmrm_pkg::MAX_REGIONS_DEF;
   // The settling pad runs past a full-table walk.
   localparam int unsigned SETTLE_PAD  = 48;
   // Descriptors per random phase.
   localparam int unsigned PHASE_ITEMS = 90;

   typedef struct {
      logic                 first;
      logic [TYPE_W-1:0]    mem_type;
      logic [ADDR_W-1:0]    phys_start;
      logic [PAGES_W-1:0]   page_count;
   } descriptor_type;

   typedef struct {
      fmrm_pkg::action_type action;
      logic [INDEX_W-1:0]   entry_index;
      logic [ADDR_W-1:0]    entry_base;
      logic [ADDR_W-1:0]    entry_size;
      logic [COUNT_W-1:0]   count_now;
      logic [ADDR_W-1:0]    bytes_total;
      logic                 map_usable;
   } map_outcome_type;

   // One row of the directed table: either the outcome is typed in by hand,
   // or it is left to the shadow table to work out.
   typedef struct {
      descriptor_type       desc;
      bit                   typed;
      map_outcome_type      want;
   } stim_row_type;

   // Shapes of random memory map
   typedef enum int unsigned {
      MAP_CLUSTER,   // well-formed map, ranges packed into a small window
      MAP_FILL,      // well-formed map of disjoint ranges, runs past a full table
      MAP_NOISE,     // single descriptor, every field random
      MAP_BROKEN     // short run with stray first flags and odd types
   } map_kind_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   logic [TYPE_W-1:0]    csr_wdata;

   fmrm_req_if req_if ();
   fmrm_rsp_if rsp_if ();

   free_memory_region_merger DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow copy of the region table, the byte total and the usable type
   // register. Entries at or above shadow_count are never read.
   // ---------------------------------------------------------------------
   logic [ADDR_W-1:0]    shadow_base [TABLE_DEPTH];
   logic [ADDR_W-1:0]    shadow_size [TABLE_DEPTH];
   int unsigned          shadow_count = 0;
   logic [ADDR_W-1:0]    shadow_total = '0;
   logic [TYPE_W-1:0]    shadow_usable_type = fmrm_pkg::USABLE_TYPE_RESET;

   // Outcomes still owed by the merger, oldest first.
   map_outcome_type      outcomes_due [$];

   int unsigned          mismatches = 0;
   int unsigned          items_sent = 0;
   // Set for the closing phase: no idling on either side.
   bit                   calm = 1'b0;

   task automatic note_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("[%0t] MISMATCH %s: got %h, want %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Applies one descriptor to the shadow table and returns the transaction
   // the merger should produce for it.
   function automatic map_outcome_type predict_merge(input descriptor_type d);
      map_outcome_type      r;
      logic [ADDR_W-1:0]    bytes;
      logic [ADDR_W-1:0]    new_end;
      logic [ADDR_W-1:0]    lo;
      logic [ADDR_W-1:0]    hi;
      bit                   hit;
      int unsigned          k;

      r.action      = fmrm_pkg::ACT_IGNORED;
      r.entry_index = '0;
      r.entry_base  = '0;
      r.entry_size  = '0;
      hit           = 1'b0;

      if (d.first) begin
         shadow_count = 0;
         shadow_total = '0;
      end

      // Page count times 4096, kept to 64 bits
      bytes = {d.page_count, {PAGE_SHIFT{1'b0}}};

      if (d.mem_type == shadow_usable_type && bytes != '0) begin
         new_end      = d.phys_start + bytes;
         shadow_total = shadow_total + bytes;

         // First stored range that overlaps or touches wins; ends wrap at 2^64.
         for (k = 0; k < shadow_count && !hit; k++) begin
            lo = shadow_base[k];
            hi = shadow_base[k] + shadow_size[k];
            if (!(new_end < lo || d.phys_start > hi)) begin
               if (d.phys_start < lo)
                  lo = d.phys_start;
               if (new_end > hi)
                  hi = new_end;
               shadow_base[k] = lo;
               shadow_size[k] = hi - lo;
               r.action       = fmrm_pkg::ACT_MERGED;
               r.entry_index  = INDEX_W'(k);
               r.entry_base   = lo;
               r.entry_size   = hi - lo;
               hit            = 1'b1;
            end
         end

         if (!hit) begin
            if (shadow_count >= TABLE_DEPTH) begin
               r.action = fmrm_pkg::ACT_DROPPED;
            end else begin
               shadow_base[shadow_count] = d.phys_start;
               shadow_size[shadow_count] = bytes;
               r.action      = fmrm_pkg::ACT_APPENDED;
               r.entry_index = INDEX_W'(shadow_count);
               r.entry_base  = d.phys_start;
               r.entry_size  = bytes;
               shadow_count++;
            end
         end
      end

      r.count_now   = COUNT_W'(shadow_count);
      r.bytes_total = shadow_total;
      r.map_usable  = (shadow_count != 0);
      return r;
   endfunction

   function automatic descriptor_type desc(input logic f, input logic [TYPE_W-1:0] t,
                                           input logic [ADDR_W-1:0] s,
                                           input logic [PAGES_W-1:0] n);
      descriptor_type d;
      d.first      = f;
      d.mem_type   = t;
      d.phys_start = s;
      d.page_count = n;
      return d;
   endfunction

   function automatic map_outcome_type outcome(input fmrm_pkg::action_type a,
                                               input logic [INDEX_W-1:0] i,
                                               input logic [ADDR_W-1:0] b,
                                               input logic [ADDR_W-1:0] z,
                                               input logic [COUNT_W-1:0] c,
                                               input logic [ADDR_W-1:0] tot,
                                               input logic u);
      map_outcome_type r;
      r.action      = a;
      r.entry_index = i;
      r.entry_base  = b;
      r.entry_size  = z;
      r.count_now   = c;
      r.bytes_total = tot;
      r.map_usable  = u;
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] any_addr();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [PAGES_W-1:0] any_pages();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[PAGES_W-1:0];
   endfunction

   // Offers one descriptor, holding valid until the merger takes it. The
   // expected outcome is queued at the edge of acceptance. An optional idle
   // burst goes in front; valid is only lowered when such a burst is taken.
   task automatic send_descriptor(input descriptor_type d, input bit typed,
                                  input map_outcome_type want);
      int unsigned      gap;
      map_outcome_type  predicted;

      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end

      req_if.valid        <= 1'b1;
      req_if.first_of_map <= d.first;
      req_if.mem_type     <= d.mem_type;
      req_if.phys_start   <= d.phys_start;
      req_if.page_count   <= d.page_count;

      @(posedge clock);
      while (req_if.ready !== 1'b1)
         @(posedge clock);

      predicted = predict_merge(d);
      if (typed)
         outcomes_due.push_back(want);
      else
         outcomes_due.push_back(predicted);
      items_sent++;
   endtask

   // Stops the sender and waits until every owed transaction has come back,
   // then lets the merger run out any walk still in flight.
   task automatic settle_block();
      req_if.valid <= 1'b0;
      while (outcomes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_PAD) @(posedge clock);
   endtask

   // The register is only touched with the merger idle.
   task automatic write_usable_type(input logic [TYPE_W-1:0] value);
      settle_block();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      shadow_usable_type = value;
   endtask

   task automatic send_map(input map_kind_type kind);
      descriptor_type      d;
      map_outcome_type     unused;
      int unsigned         n;
      int unsigned         i;
      logic [ADDR_W-1:0]   window;

      case ($urandom_range(0, 2))
         0: window = '0;
         1: window = 64'hFFFF_FFFF_FFFC_0000;   // ends of later ranges wrap past zero
         default: window = any_addr() & ~64'h3_FFFF;
      endcase

      case (kind)
         MAP_CLUSTER: begin
            n = $urandom_range(2, 40);
            for (i = 0; i < n; i++) begin
               d.first      = (i == 0);
               d.mem_type   = ($urandom_range(0, 9) == 0) ? TYPE_W'($urandom)
                                                          : shadow_usable_type;
               d.phys_start = window + 64'($urandom_range(0, 63)) * 64'h1000;
               if ($urandom_range(0, 7) == 0)
                  d.phys_start = d.phys_start + 64'($urandom_range(1, 4095));
               d.page_count = PAGES_W'($urandom_range(0, 8));
               send_descriptor(d, 1'b0, unused);
            end
         end
         MAP_FILL: begin
            // 2 MiB apart with at most 64 KiB each: nothing touches, so the
            // table fills and the tail gets dropped.
            window = any_addr() & ~64'h3FFF_FFFF;
            n = $urandom_range(33, 37);
            for (i = 0; i < n; i++) begin
               d.first      = (i == 0);
               d.mem_type   = shadow_usable_type;
               d.phys_start = window + 64'(i) * 64'h20_0000
                              + 64'($urandom_range(0, 15)) * 64'h1000;
               d.page_count = PAGES_W'($urandom_range(1, 16));
               send_descriptor(d, 1'b0, unused);
            end
         end
         MAP_NOISE: begin
            d.first      = 1'($urandom_range(0, 1));
            d.mem_type   = $urandom_range(0, 1) ? TYPE_W'($urandom) : shadow_usable_type;
            d.phys_start = any_addr();
            d.page_count = any_pages();
            send_descriptor(d, 1'b0, unused);
         end
         default: begin
            n = $urandom_range(2, 10);
            for (i = 0; i < n; i++) begin
               d.first      = ($urandom_range(0, 3) == 0);
               d.mem_type   = $urandom_range(0, 2) ? shadow_usable_type : TYPE_W'($urandom);
               d.phys_start = window + 64'($urandom_range(0, 4095)) * 64'h100;
               d.page_count = PAGES_W'($urandom_range(0, 3));
               send_descriptor(d, 1'b0, unused);
            end
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Result side back-pressure: random bursts of low ready, none once calm.
   // ---------------------------------------------------------------------
   initial begin
      int unsigned hold;
      hold = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (calm) begin
            rsp_if.ready <= 1'b1;
         end else if (hold != 0) begin
            rsp_if.ready <= 1'b0;
            hold--;
         end else if ($urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            hold = $urandom_range(0, 5);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: every accepted transaction against the oldest owed one.
   // Values are read at the edge, before any update scheduled for it.
   // ---------------------------------------------------------------------
   initial begin
      map_outcome_type w;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (outcomes_due.size() == 0) begin
               note_mismatch("transaction with nothing owed, action", 64'(rsp_if.action), '0);
            end else begin
               w = outcomes_due.pop_front();
               if (rsp_if.action !== w.action)
                  note_mismatch("action", 64'(rsp_if.action), 64'(w.action));
               if (rsp_if.entry_index !== w.entry_index)
                  note_mismatch("entry_index", 64'(rsp_if.entry_index), 64'(w.entry_index));
               if (rsp_if.entry_base !== w.entry_base)
                  note_mismatch("entry_base", rsp_if.entry_base, w.entry_base);
               if (rsp_if.entry_size !== w.entry_size)
                  note_mismatch("entry_size", rsp_if.entry_size, w.entry_size);
               if (rsp_if.count_now !== w.count_now)
                  note_mismatch("count_now", 64'(rsp_if.count_now), 64'(w.count_now));
               if (rsp_if.bytes_total !== w.bytes_total)
                  note_mismatch("bytes_total", rsp_if.bytes_total, w.bytes_total);
               if (rsp_if.map_usable !== w.map_usable)
                  note_mismatch("map_usable", 64'(rsp_if.map_usable), 64'(w.map_usable));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      stim_row_type        rows [$];
      stim_row_type        row;
      logic [TYPE_W-1:0]   phase_type [4];
      int unsigned         p;
      int unsigned         target;
      bit                  opened;
      bit                  paused;
      map_kind_type        kind;

      req_if.valid        <= 1'b0;
      req_if.first_of_map <= 1'b0;
      req_if.mem_type     <= '0;
      req_if.phys_start   <= '0;
      req_if.page_count   <= '0;
      csr_we              <= 1'b0;
      csr_wdata           <= '0;

      // Directed table, usable type at its reset value of 7.
      // Wrong type straight after reset: nothing held, nothing counted.
      row.typed = 1'b1;
      row.desc = desc(0, 8'd3, 64'h0, 52'd5);
      row.want = outcome(fmrm_pkg::ACT_IGNORED, 0, 0, 0, 0, 0, 0);
      rows.push_back(row);
      // Right type but zero pages is ignored too.
      row.desc = desc(0, 8'd7, 64'hFFFF_FFFF_FFFF_FFFF, 52'd0);
      rows.push_back(row);
      // Opening a map with one page lands in entry 0.
      row.desc = desc(1, 8'd7, 64'h0, 52'd1);
      row.want = outcome(fmrm_pkg::ACT_APPENDED, 0, 64'h0, 64'h1000, 1, 64'h1000, 1);
      rows.push_back(row);
      row.typed = 1'b0;
      row.desc = desc(0, 8'd7, 64'h2000, 52'd1);          // gap: new entry
      rows.push_back(row);
      row.desc = desc(0, 8'd7, 64'h1000, 52'd1);          // touches both, first wins
      rows.push_back(row);
      row.desc = desc(0, 8'd7, 64'h3000, 52'd2);          // starts at an entry's end
      rows.push_back(row);
      row.desc = desc(0, 8'd7, 64'h1_0000, 52'd1);
      rows.push_back(row);
      row.desc = desc(0, 8'd7, 64'hF000, 52'd1);          // ends at an entry's start
      rows.push_back(row);
      row.desc = desc(0, 8'd7, 64'h0, 52'h10);            // spans several, only one widened
      rows.push_back(row);
      // New map at the very top: its end wraps to zero.
      row.typed = 1'b1;
      row.desc = desc(1, 8'd7, 64'hFFFF_FFFF_FFFF_F000, 52'd1);
      row.want = outcome(fmrm_pkg::ACT_APPENDED, 0, 64'hFFFF_FFFF_FFFF_F000, 64'h1000, 1,
                         64'h1000, 1);
      rows.push_back(row);
      row.typed = 1'b0;
      row.desc = desc(0, 8'd7, 64'h0, 52'd1);             // wrapped end compares low
      rows.push_back(row);
      row.desc = desc(0, 8'd7, 64'hFFFF_FFFF_FFFF_E000, 52'd1);
      rows.push_back(row);
      // Largest page count from address zero.
      row.typed = 1'b1;
      row.desc = desc(1, 8'd7, 64'h0, 52'hF_FFFF_FFFF_FFFF);
      row.want = outcome(fmrm_pkg::ACT_APPENDED, 0, 64'h0, 64'hFFFF_FFFF_FFFF_F000, 1,
                         64'hFFFF_FFFF_FFFF_F000, 1);
      rows.push_back(row);
      row.typed = 1'b0;
      row.desc = desc(0, 8'd7, 64'hFFFF_FFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF); // total wraps
      rows.push_back(row);
      row.desc = desc(0, 8'hFF, 64'h5555_5555_5555_5555, 52'hA_AAAA_AAAA_AAAA);
      rows.push_back(row);
      // Ignored descriptor still clears the map when it opens one.
      row.typed = 1'b1;
      row.desc = desc(1, 8'h00, 64'hAAAA_AAAA_AAAA_AAAA, 52'h5_5555_5555_5555);
      row.want = outcome(fmrm_pkg::ACT_IGNORED, 0, 0, 0, 0, 0, 0);
      rows.push_back(row);
      row.typed = 1'b0;
      row.desc = desc(0, 8'd7, 64'hAAAA_AAAA_AAAA_A000, 52'h5_5555_5555_5555);
      rows.push_back(row);
      row.desc = desc(0, 8'd7, 64'h8000_0000_0000_0123, 52'd3);
      rows.push_back(row);
      row.desc = desc(0, 8'd7, 64'h7FFF_FFFF_FFFF_D123, 52'd3); // unaligned, touches below
      rows.push_back(row);
      row.typed = 1'b1;
      row.desc = desc(1, 8'd7, 64'h1234_5000, 52'd0);
      row.want = outcome(fmrm_pkg::ACT_IGNORED, 0, 0, 0, 0, 0, 0);
      rows.push_back(row);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         send_descriptor(rows[i].desc, rows[i].typed, rows[i].want);

      // Random phases over a spread of usable type settings, extremes first,
      // and back to the reset value for the calm closing phase.
      phase_type[0] = 8'h00;
      phase_type[1] = 8'hFF;
      phase_type[2] = TYPE_W'($urandom_range(1, 254));
      phase_type[3] = fmrm_pkg::USABLE_TYPE_RESET;
      paused = 1'b0;

      for (p = 0; p < 4; p++) begin
         write_usable_type(phase_type[p]);
         if (p == 3)
            calm = 1'b1;
         target = items_sent + PHASE_ITEMS;
         opened = 1'b0;
         while (items_sent < target) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: kind = MAP_CLUSTER;
               6, 7:             kind = MAP_FILL;
               8:                kind = MAP_NOISE;
               default:          kind = MAP_BROKEN;
            endcase
            // Each phase opens with a table overrun.
            if (!opened)
               kind = MAP_FILL;
            opened = 1'b1;
            send_map(kind);
            // Once, mid-phase, let the result side run completely dry.
            if (p == 1 && !paused && items_sent + PHASE_ITEMS / 2 >= target) begin
               settle_block();
               paused = 1'b1;
            end
         end
      end

      settle_block();
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog: well beyond the slowest legal run.
   initial begin
      #1_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/fmrm_pkg.sv
rtl/fmrm_ifs.sv
rtl/free_memory_region_merger.sv
sim/tb_top.sv
